FILE: rtl/sic_pkg.sv
// Package for the SSH identification line classifier: codes, limits and match tables.
`default_nettype none

package sic_pkg;

    localparam int MAX_LINE_DEF = 255;

    // Parse phases
    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_PROTO   = 2'd1;
    localparam logic [1:0] PH_SOFT    = 2'd2;
    localparam logic [1:0] PH_COMMENT = 2'd3;

    // Line classes
    localparam logic [2:0] CL_NOT_SSH     = 3'd0;
    localparam logic [2:0] CL_MALFORMED   = 3'd1;
    localparam logic [2:0] CL_ACCEPTED    = 3'd2;
    localparam logic [2:0] CL_FALLBACK    = 3'd3;
    localparam logic [2:0] CL_UNSUPPORTED = 3'd4;

    // Configuration register indexes
    localparam logic REG_FALLBACK = 1'b0;
    localparam logic REG_COMPAT   = 1'b1;

    localparam int         COMPAT_ENTRIES = 4;
    localparam logic [7:0] CH_DASH        = 8'h2D;
    localparam logic [7:0] CH_SPACE       = 8'h20;

    function automatic logic [7:0] ident_head_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h53;
            2'd1:    c = 8'h53;
            2'd2:    c = 8'h48;
            default: c = CH_DASH;
        endcase
        return c;
    endfunction

    // "2.0"
    function automatic logic [7:0] ver_two_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h32;
            2'd1:    c = 8'h2E;
            2'd2:    c = 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "1.99"
    function automatic logic [7:0] ver_one99_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h31;
            2'd1:    c = 8'h2E;
            default: c = 8'h39;
        endcase
        return c;
    endfunction

    // "1."
    function automatic logic [7:0] ver_one_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h31;
            default: c = 8'h2E;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] compat_len(input logic [1:0] entry);
        logic [3:0] n;
        case (entry)
            2'd0:    n = 4'd4;
            2'd1:    n = 4'd5;
            2'd2:    n = 4'd3;
            default: n = 4'd11;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] compat_flags(input logic [1:0] entry);
        logic [5:0] f;
        case (entry)
            2'd0:    f = 6'h1F;
            2'd1:    f = 6'h0D;
            2'd2:    f = 6'h08;
            default: f = 6'h20;
        endcase
        return f;
    endfunction

    // Software version prefix table, one byte per call
    function automatic logic [7:0] compat_char(input logic [1:0] entry,
                                               input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (entry)
            2'd0: begin
                case (idx)
                    4'd0:    c = 8'h32;
                    4'd1:    c = 8'h2E;
                    4'd2:    c = 8'h30;
                    4'd3:    c = 8'h2E;
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    4'd0:    c = 8'h32;
                    4'd1:    c = 8'h2E;
                    4'd2:    c = 8'h31;
                    4'd3:    c = 8'h2E;
                    4'd4:    c = 8'h30;
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                case (idx)
                    4'd0:    c = 8'h33;
                    4'd1:    c = 8'h2E;
                    4'd2:    c = 8'h30;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    c = 8'h53;
                    4'd1:    c = 8'h75;
                    4'd2:    c = 8'h6E;
                    4'd3:    c = 8'h5F;
                    4'd4:    c = 8'h53;
                    4'd5:    c = 8'h53;
                    4'd6:    c = 8'h48;
                    4'd7:    c = 8'h5F;
                    4'd8:    c = 8'h31;
                    4'd9:    c = 8'h2E;
                    4'd10:   c = 8'h30;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ssh_ident_line_classifier_top.sv
// SSH identification line classifier: top level, byte-per-cycle parser.
// Throughput: one byte per cycle, stalled only while a result waits under out_stall;
// the per-byte parse step sits between the input register and the result register.
// Reset (rst_n, async, active low) clears parse state, valids and config
// (fallback_enable = 0, compat_enable = 1).
`default_nettype none

module ssh_ident_line_classifier_top
    import sic_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_write_enable,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] line_byte,
    input  wire logic       last_byte,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      line_class,
    output logic [7:0]      protocol_length,
    output logic [7:0]      software_length,
    output logic [7:0]      comment_length,
    output logic [5:0]      bug_flags
);

    localparam int CNT_W  = $clog2(MAX_LINE + 1);
    localparam int WIDE_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_LINE);
    localparam logic [WIDE_W-1:0] LEN_CAP = WIDE_W'(255);

    // configuration
    logic fallback_en_reg;
    logic compat_en_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // parse state
    logic [2:0]       pos_reg, pos_next;       // only "below 4" matters; saturates at 4
    logic [1:0]       phase_reg, phase_next;
    logic             prefix_ok_reg, prefix_ok_next;
    logic [CNT_W-1:0] proto_cnt_reg, proto_cnt_next;
    logic [CNT_W-1:0] soft_cnt_reg, soft_cnt_next;
    logic [CNT_W-1:0] cmt_cnt_reg, cmt_cnt_next;
    logic [2:0]       ver_match_reg, ver_match_next;
    logic [3:0]       compat_match_reg, compat_match_next;

    // result register
    logic       out_valid_reg;
    logic [2:0] class_reg;
    logic [7:0] proto_len_reg, soft_len_reg, cmt_len_reg;
    logic [5:0] flags_reg;

    logic       advance;
    logic       step;
    logic [2:0] class_next;
    logic [7:0] proto_len_next, soft_len_next, cmt_len_next;
    logic [5:0] flags_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
    endfunction

    function automatic logic [7:0] cap_len(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return (w > LEN_CAP) ? 8'hFF : w[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_en_reg <= 1'b0;
            compat_en_reg   <= 1'b1;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_FALLBACK: fallback_en_reg <= cfg_data;
                REG_COMPAT:   compat_en_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= line_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Per-byte parse step
    always_comb
    begin
        logic [7:0]       b;
        logic [1:0]       pidx;
        logic [CNT_W-1:0] s;
        logic [3:0]       sidx;
        b    = s1_byte_reg;
        pidx = proto_cnt_reg[1:0];
        s    = soft_cnt_reg;
        sidx = s[3:0];

        pos_next          = (pos_reg < 3'd4) ? pos_reg + 3'd1 : pos_reg;
        phase_next        = phase_reg;
        prefix_ok_next    = prefix_ok_reg;
        proto_cnt_next    = proto_cnt_reg;
        soft_cnt_next     = soft_cnt_reg;
        cmt_cnt_next      = cmt_cnt_reg;
        ver_match_next    = ver_match_reg;
        compat_match_next = compat_match_reg;

        case (phase_reg)
            PH_PREFIX:
            begin
                if (prefix_ok_reg && pos_reg < 3'd4)
                begin
                    if (b != ident_head_char(pos_reg[1:0]))
                        prefix_ok_next = 1'b0;
                    if (pos_reg == 3'd3 && b == ident_head_char(pos_reg[1:0]))
                        phase_next = PH_PROTO;
                end
            end
            PH_PROTO:
            begin
                if (b == CH_DASH)
                    phase_next = PH_SOFT;
                else
                begin
                    if (proto_cnt_reg < CNT_W'(3) && b != ver_two_char(pidx))
                        ver_match_next[0] = 1'b0;
                    if (proto_cnt_reg >= CNT_W'(4) || b != ver_one99_char(pidx))
                        ver_match_next[1] = 1'b0;
                    if (proto_cnt_reg < CNT_W'(2) && b != ver_one_char(pidx))
                        ver_match_next[2] = 1'b0;
                    proto_cnt_next = sat_inc(proto_cnt_reg);
                end
            end
            PH_SOFT:
            begin
                if (b == CH_SPACE)
                    phase_next = PH_COMMENT;
                else
                begin
                    for (int i = 0; i < COMPAT_ENTRIES; i++)
                    begin
                        if (s < CNT_W'(compat_len(2'(i))) &&
                            b != compat_char(2'(i), sidx))
                            compat_match_next[i] = 1'b0;
                    end
                    soft_cnt_next = sat_inc(soft_cnt_reg);
                end
            end
            default:
                cmt_cnt_next = sat_inc(cmt_cnt_reg);
        endcase
    end

    // Line verdict from the updated state
    always_comb
    begin
        logic lens;
        logic hit;
        lens       = 1'b0;
        hit        = 1'b0;
        flags_next = 6'd0;
        if (phase_next == PH_PREFIX)
            class_next = CL_NOT_SSH;
        else if (phase_next == PH_PROTO)
            class_next = CL_MALFORMED;
        else
        begin
            lens = 1'b1;
            if ((ver_match_next[0] && proto_cnt_next >= CNT_W'(3)) ||
                (ver_match_next[1] && proto_cnt_next == CNT_W'(4)))
            begin
                class_next = CL_ACCEPTED;
                if (compat_en_reg)
                begin
                    // first alive entry whose whole prefix was seen wins
                    for (int i = 0; i < COMPAT_ENTRIES; i++)
                    begin
                        if (!hit && compat_match_next[i] &&
                            soft_cnt_next >= CNT_W'(compat_len(2'(i))))
                        begin
                            hit        = 1'b1;
                            flags_next = compat_flags(2'(i));
                        end
                    end
                end
            end
            else if (fallback_en_reg && ver_match_next[2] &&
                     proto_cnt_next >= CNT_W'(2))
                class_next = CL_FALLBACK;
            else
                class_next = CL_UNSUPPORTED;
        end
        proto_len_next = lens ? cap_len(proto_cnt_next) : 8'd0;
        soft_len_next  = lens ? cap_len(soft_cnt_next)  : 8'd0;
        cmt_len_next   = lens ? cap_len(cmt_cnt_next)   : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= 3'd0;
            phase_reg        <= PH_PREFIX;
            prefix_ok_reg    <= 1'b1;
            proto_cnt_reg    <= '0;
            soft_cnt_reg     <= '0;
            cmt_cnt_reg      <= '0;
            ver_match_reg    <= 3'b111;
            compat_match_reg <= 4'b1111;
        end
        else if (step)
        begin
            if (s1_last_reg)
            begin
                pos_reg          <= 3'd0;
                phase_reg        <= PH_PREFIX;
                prefix_ok_reg    <= 1'b1;
                proto_cnt_reg    <= '0;
                soft_cnt_reg     <= '0;
                cmt_cnt_reg      <= '0;
                ver_match_reg    <= 3'b111;
                compat_match_reg <= 4'b1111;
            end
            else
            begin
                pos_reg          <= pos_next;
                phase_reg        <= phase_next;
                prefix_ok_reg    <= prefix_ok_next;
                proto_cnt_reg    <= proto_cnt_next;
                soft_cnt_reg     <= soft_cnt_next;
                cmt_cnt_reg      <= cmt_cnt_next;
                ver_match_reg    <= ver_match_next;
                compat_match_reg <= compat_match_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
        begin
            class_reg     <= class_next;
            proto_len_reg <= proto_len_next;
            soft_len_reg  <= soft_len_next;
            cmt_len_reg   <= cmt_len_next;
            flags_reg     <= flags_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_class      = class_reg;
    assign protocol_length = proto_len_reg;
    assign software_length = soft_len_reg;
    assign comment_length  = cmt_len_reg;
    assign bug_flags       = flags_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result appeared without a last byte");

    a_no_lens_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (class_reg == CL_NOT_SSH || class_reg == CL_MALFORMED))
        |-> (proto_len_reg == 8'd0 && soft_len_reg == 8'd0 && cmt_len_reg == 8'd0))
        else $error("lengths reported for a rejected line");

    a_flags_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flags_reg != 6'd0) |-> (class_reg == CL_ACCEPTED))
        else $error("peer flags on a line that was not accepted");
`endif

endmodule

`default_nettype wire
